### rtl/k_nearest_sorted_keeper_assert.svh
// Assertion macros for the sorted top-k keeper checker.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef K_NEAREST_SORTED_KEEPER_ASSERT_SVH
`define K_NEAREST_SORTED_KEEPER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define KNSK_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define KNSK_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define KNSK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/knsk_pkg.sv
// Shared constants and types for the sorted top-k keeper.
// Used by the interfaces, the list cell, the top level and the checker.
package knsk_pkg;

    localparam int MAX_KEEP = 16;
    localparam int IDX_W    = $clog2(MAX_KEEP);
    localparam int CNT_W    = 5;
    localparam int ID_W     = 32;
    localparam int DIST_W   = 32;
    localparam int KIND_W   = 2;

    localparam logic [KIND_W-1:0] KIND_OFFER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // Broadcast from the control to every cell.
    typedef struct packed {
        logic              offer;
        logic [ID_W-1:0]   cand_id;
        logic [DIST_W-1:0] cand_distance;
    } t_cell_bcast;

    // What one cell hands to its right-hand neighbor.
    typedef struct packed {
        logic              gt;
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
    } t_cell_link;

    typedef struct packed {
        logic              accepted;
        logic [CNT_W-1:0]  position;
        logic              entry_valid;
        logic [ID_W-1:0]   entry_id;
        logic [DIST_W-1:0] entry_distance;
        logic [CNT_W-1:0]  held_count;
        logic              last;
    } t_rsp;

endpackage

### rtl/knsk_if.sv
// Request and response channel interfaces of the sorted top-k keeper.
// Depends on knsk_pkg for field widths.
interface knsk_req_if;
    logic                          valid;
    logic                          ready;
    logic [knsk_pkg::KIND_W-1:0]   kind;
    logic [knsk_pkg::ID_W-1:0]     candidate_id;
    logic [knsk_pkg::DIST_W-1:0]   candidate_distance;

    modport source (output valid, kind, candidate_id, candidate_distance, input ready);
    modport sink   (input valid, kind, candidate_id, candidate_distance, output ready);
endinterface

interface knsk_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          accepted;
    logic [knsk_pkg::CNT_W-1:0]    position;
    logic                          entry_valid;
    logic [knsk_pkg::ID_W-1:0]     entry_id;
    logic [knsk_pkg::DIST_W-1:0]   entry_distance;
    logic [knsk_pkg::CNT_W-1:0]    held_count;
    logic                          last;

    modport source (output valid, accepted, position, entry_valid, entry_id,
                    entry_distance, held_count, last, input ready);
    modport sink   (input valid, accepted, position, entry_valid, entry_id,
                    entry_distance, held_count, last, output ready);
endinterface

### rtl/knsk_cell.sv
// One rank of the sorted list: holds an entry and takes part in insertion.
// Depends on knsk_pkg for the broadcast and neighbor link types.
module knsk_cell (
    input  logic                  i_clk,
    input  knsk_pkg::t_cell_bcast i_bcast,
    input  logic                  i_held,
    input  logic                  i_append,
    input  knsk_pkg::t_cell_link  i_link,
    output knsk_pkg::t_cell_link  o_link
);

    logic [knsk_pkg::ID_W-1:0]   r_id;
    logic [knsk_pkg::ID_W-1:0]   n_id;
    logic [knsk_pkg::DIST_W-1:0] r_dist;
    logic [knsk_pkg::DIST_W-1:0] n_dist;
    logic                        w_gt;

    always_comb begin
        w_gt   = i_held && (r_dist > i_bcast.cand_distance);
        n_id   = r_id;
        n_dist = r_dist;
        if (i_bcast.offer) begin
            if (i_link.gt) begin
                // The insertion point lies to the left: move one rank down.
                n_id   = i_link.id;
                n_dist = i_link.distance;
            end else if (w_gt || i_append) begin
                n_id   = i_bcast.cand_id;
                n_dist = i_bcast.cand_distance;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_dist <= n_dist;
    end

    assign o_link = '{gt: w_gt, id: r_id, distance: r_dist};

endmodule

### rtl/k_nearest_sorted_keeper.sv
// Sorted top-k keeper. The request channel i_req carries offers, clears and
// read-outs; o_rsp returns one response per offer, clear or unknown kind, and
// one response per held entry for a read-out (one response if the list is
// empty), the final one flagged by last. keep_count is to be written through
// i_cfg_wr_en / i_cfg_wr_data only while the block is idle; the block itself
// does not enforce this. Values above 16 act as 16. The (first) response to
// an accepted request is registered and shows in the cycle after it. Offers,
// clears and unknown kinds are taken one per cycle while the receiver keeps
// up, since the insertion is done by one compare in every cell of the chain
// in parallel. A read-out of n entries gives them one per cycle while the
// receiver keeps up; no request is taken until its last response is loaded.
// A synchronous low i_rst_n empties the list, zeroes keep_count and drops
// any pending response. When the receiver stalls, the response stays in its
// register and a new request is taken only in the cycle that frees it, so
// nothing is lost or repeated.
module k_nearest_sorted_keeper (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    knsk_req_if.sink                            i_req,
    knsk_rsp_if.source                          o_rsp,
    input  logic                                i_cfg_wr_en,
    input  logic [knsk_pkg::CNT_W-1:0]          i_cfg_wr_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    localparam int MK    = knsk_pkg::MAX_KEEP;
    localparam int IDX_W = knsk_pkg::IDX_W;
    localparam int CNT_W = knsk_pkg::CNT_W;

    // Control state.
    logic                  r_state;
    logic                  n_state;
    logic [IDX_W-1:0]      r_rd_idx;
    logic [IDX_W-1:0]      n_rd_idx;
    logic [CNT_W-1:0]      r_total;
    logic [CNT_W-1:0]      n_total;
    logic [CNT_W-1:0]      r_keep;
    logic                  r_out_valid;
    logic                  n_out_valid;
    knsk_pkg::t_rsp        r_out;
    knsk_pkg::t_rsp        n_out;

    // Chain of cells.
    knsk_pkg::t_cell_bcast w_bcast;
    knsk_pkg::t_cell_link  w_link [MK];
    logic [MK-1:0]         w_gt_vec;
    logic [MK-1:0]         w_held_vec;
    logic [MK-1:0]         w_first_vec;
    logic [MK-1:0]         w_append_vec;

    // Offer decision.
    logic                  w_slot_free;
    logic                  w_in_acc;
    logic                  w_offer_go;
    logic [CNT_W-1:0]      w_k;
    logic                  w_ins;
    logic [IDX_W-1:0]      w_ins_pos;
    logic [CNT_W:0]        w_tot_p;
    logic                  w_drop;
    logic                  w_app;
    logic [IDX_W-1:0]      w_last_idx;
    logic [IDX_W-1:0]      w_sel_idx;
    knsk_pkg::t_cell_link  w_sel;
    logic                  w_rd_last;

    assign w_slot_free = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == ST_IDLE) && w_slot_free;
    assign w_in_acc    = i_req.valid && i_req.ready;
    assign w_offer_go  = w_in_acc && (i_req.kind == knsk_pkg::KIND_OFFER);

    assign w_k = (r_keep > CNT_W'(MK)) ? CNT_W'(MK) : r_keep;

    assign w_bcast = '{offer:         w_offer_go,
                       cand_id:       i_req.candidate_id,
                       cand_distance: i_req.candidate_distance};

    genvar g;
    generate
        for (g = 0; g < MK; g++) begin : g_cell
            knsk_pkg::t_cell_link w_left;
            if (g == 0) begin : g_head
                assign w_left = '0;
            end else begin : g_body
                assign w_left = w_link[g-1];
            end
            knsk_cell u_cell (
                .i_clk    (i_clk),
                .i_bcast  (w_bcast),
                .i_held   (w_held_vec[g]),
                .i_append (w_append_vec[g]),
                .i_link   (w_left),
                .o_link   (w_link[g])
            );
        end
    endgenerate

    // Since the list is sorted, the cells whose entry is farther than the
    // candidate form one run at the tail; the first of them marks the rank.
    always_comb begin
        w_ins_pos = '0;
        for (int i = 0; i < MK; i++) begin
            w_gt_vec[i]   = w_link[i].gt;
            w_held_vec[i] = CNT_W'(i) < r_total;
        end
        w_first_vec = w_gt_vec & ~(w_gt_vec << 1);
        for (int i = 0; i < MK; i++) begin
            if (w_first_vec[i]) begin
                w_ins_pos = w_ins_pos | IDX_W'(i);
            end
        end
    end

    assign w_ins   = |w_gt_vec;
    assign w_tot_p = {1'b0, r_total} + {{CNT_W{1'b0}}, w_ins};
    assign w_drop  = w_tot_p > {1'b0, w_k};
    assign w_app   = !w_ins && (r_total < w_k);

    always_comb begin
        for (int i = 0; i < MK; i++) begin
            w_append_vec[i] = w_offer_go && w_app && (CNT_W'(i) == r_total);
        end
    end

    // The dropped entry is always the one held at the old tail, whether or
    // not the candidate went in ahead of it.
    assign w_last_idx = IDX_W'(r_total - CNT_W'(1));
    assign w_rd_last  = ({1'b0, r_rd_idx} == CNT_W'(r_total - CNT_W'(1)));

    always_comb begin
        if (r_state == ST_READ) begin
            w_sel_idx = r_rd_idx;
        end else if (i_req.kind == knsk_pkg::KIND_READ) begin
            w_sel_idx = '0;
        end else begin
            w_sel_idx = w_last_idx;
        end
    end
    assign w_sel = w_link[w_sel_idx];

    always_comb begin
        n_state     = r_state;
        n_rd_idx    = r_rd_idx;
        n_total     = r_total;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        if (r_state == ST_READ) begin
            if (w_slot_free) begin
                n_out_valid          = 1'b1;
                n_out                = '0;
                n_out.position       = {1'b0, r_rd_idx};
                n_out.entry_valid    = 1'b1;
                n_out.entry_id       = w_sel.id;
                n_out.entry_distance = w_sel.distance;
                n_out.held_count     = r_total;
                n_out.last           = w_rd_last;
                if (w_rd_last) begin
                    n_state = ST_IDLE;
                end else begin
                    n_rd_idx = IDX_W'(r_rd_idx + IDX_W'(1));
                end
            end
        end else if (w_in_acc) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            n_out.last  = 1'b1;
            case (i_req.kind)
                knsk_pkg::KIND_OFFER: begin
                    if (w_drop) begin
                        n_total = CNT_W'(w_tot_p - (CNT_W+1)'(1));
                    end else begin
                        n_total = w_tot_p[CNT_W-1:0] + {{(CNT_W-1){1'b0}}, w_app};
                    end
                    n_out.accepted = w_ins || w_app;
                    if (w_ins) begin
                        n_out.position = {1'b0, w_ins_pos};
                    end else if (w_app) begin
                        n_out.position = r_total;
                    end
                    n_out.entry_valid = w_drop;
                    if (w_drop) begin
                        n_out.entry_id       = w_sel.id;
                        n_out.entry_distance = w_sel.distance;
                    end
                    n_out.held_count = n_total;
                end
                knsk_pkg::KIND_CLEAR: begin
                    n_total = '0;
                end
                knsk_pkg::KIND_READ: begin
                    if (r_total != '0) begin
                        n_out.entry_valid    = 1'b1;
                        n_out.entry_id       = w_sel.id;
                        n_out.entry_distance = w_sel.distance;
                        n_out.held_count     = r_total;
                        n_out.last           = (r_total == CNT_W'(1));
                        if (r_total != CNT_W'(1)) begin
                            n_state  = ST_READ;
                            n_rd_idx = IDX_W'(1);
                        end
                    end
                end
                default: begin
                    // Unknown kind: the list is left alone.
                    n_out.held_count = r_total;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_idx    <= '0;
            r_total     <= '0;
            r_keep      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_idx    <= n_rd_idx;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_keep <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.accepted       = r_out.accepted;
    assign o_rsp.position       = r_out.position;
    assign o_rsp.entry_valid    = r_out.entry_valid;
    assign o_rsp.entry_id       = r_out.entry_id;
    assign o_rsp.entry_distance = r_out.entry_distance;
    assign o_rsp.held_count     = r_out.held_count;
    assign o_rsp.last           = r_out.last;

endmodule

### rtl/knsk_checker.sv
// Port-level checks for the sorted top-k keeper, bound to its top level.
// Depends on knsk_pkg and the assertion macro header.
`include "k_nearest_sorted_keeper_assert.svh"

module knsk_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_out_accepted,
    input logic [knsk_pkg::CNT_W-1:0]    i_out_position,
    input logic                          i_out_entry_valid,
    input logic [knsk_pkg::ID_W-1:0]     i_out_entry_id,
    input logic [knsk_pkg::DIST_W-1:0]   i_out_entry_distance,
    input logic [knsk_pkg::CNT_W-1:0]    i_out_held_count,
    input logic                          i_out_last
);

    // A stalled response keeps its entry, position and last flag.
    `KNSK_ASSERT_NEXT(a_rsp_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_entry_id) && $stable(i_out_entry_distance) && $stable(i_out_position) && $stable(i_out_last), "stalled response changed")

    // The list never reports more entries than it can hold.
    `KNSK_ASSERT_IMPL(a_held_max, i_out_valid, i_out_held_count <= knsk_pkg::CNT_W'(knsk_pkg::MAX_KEEP), "held count above list size")

    // An accepted candidate sits at a rank inside the list that remains.
    `KNSK_ASSERT_IMPL(a_acc_rank, i_out_valid && i_out_accepted, i_out_position < i_out_held_count, "accepted rank outside list")

    // While a read-out is still going, no new request may be taken.
    `KNSK_ASSERT_IMPL(a_read_blocks, i_out_valid && !i_out_last, !i_in_ready, "request taken during read-out")

    // Entry fields without a dropped or read entry are zero.
    `KNSK_ASSERT_IMPL(a_entry_zero, i_out_valid && !i_out_entry_valid, (i_out_entry_id == '0) && (i_out_entry_distance == '0), "entry fields set without entry")

endmodule

bind k_nearest_sorted_keeper knsk_checker u_knsk_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_ready           (i_req.ready),
    .i_out_valid          (o_rsp.valid),
    .i_out_ready          (o_rsp.ready),
    .i_out_accepted       (o_rsp.accepted),
    .i_out_position       (o_rsp.position),
    .i_out_entry_valid    (o_rsp.entry_valid),
    .i_out_entry_id       (o_rsp.entry_id),
    .i_out_entry_distance (o_rsp.entry_distance),
    .i_out_held_count     (o_rsp.held_count),
    .i_out_last           (o_rsp.last)
);
